// File: rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types, register codes and helpers for the tiled texture swizzle
// and box downscale block.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TILES_ACROSS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STORED_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STORED_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWNSHIFT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_X        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_Y        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT   = 3'd7;

    // One classified sample on its way to the accumulator.
    typedef struct packed {
        logic [31:0] texel;
        logic [10:0] dx;
        logic [19:0] addr;
        logic        first;
        logic        last;
    } t_item;

    typedef struct packed {
        logic                   full;
        logic                   empty;
        logic [QUEUE_CNT_W-1:0] count;
    } t_q_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ACC,
        BK_DIV,
        BK_OUT
    } t_back_state;

    // Interleave x and y bits inside an 8x8 tile, x in the even positions.
    function automatic logic [5:0] morton3(input logic [2:0] x, input logic [2:0] y);
        morton3 = {y[2], x[2], y[1], x[1], y[0], x[0]};
    endfunction

    // Rectangle size: zero acts as one, anything above 8192 as 8192.
    function automatic logic [13:0] rect_dim(input logic [13:0] v);
        if (v == 14'd0) begin
            rect_dim = 14'd1;
        end else if (v > 14'd8192) begin
            rect_dim = 14'd8192;
        end else begin
            rect_dim = v;
        end
    endfunction

endpackage

// File: rtl/tiled_texture_swizzle_downscale.sv
// ----------------------------------------------------------------------------
// tiled_texture_swizzle_downscale
// Box-downscales a raster texel stream and writes it to 8x8 Morton tiles.
//
//   channel   signals                                 direction
//   texel     i_valid / o_ready, i_src_texel          in
//   result    o_valid / i_ready, o_word_address,      out
//             o_write_data
//   config    i_cfg_valid / o_cfg_ready, i_cfg_index, in
//             i_cfg_data
//
// The front accepts one texel a cycle while its 4-entry queue has room.
// The back reads the accumulator (BK_IDLE), then adds and writes (BK_ACC)
// per kept texel; the last sample of a block then runs the divider (BK_DIV)
// and holds the result in BK_OUT until taken, with no new sample popped
// meanwhile. Reset is synchronous and needs no clearing pass. A stalled
// result holds the back while the front keeps filling the queue.
// ----------------------------------------------------------------------------
module tiled_texture_swizzle_downscale #(
    parameter int MAX_STORED_WIDTH = 1024,
    parameter int MAX_DOWNSHIFT    = 3
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [31:0]                    i_src_texel,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [19:0]                    o_word_address,
    output logic [31:0]                    o_write_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tts_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic               push;
    logic               pop;
    tts_pkg::t_item     f_item;
    tts_pkg::t_item     q_item;
    tts_pkg::t_q_status q_status;

    tts_front #(
        .MAX_STORED_WIDTH(MAX_STORED_WIDTH),
        .MAX_DOWNSHIFT   (MAX_DOWNSHIFT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_src_texel(i_src_texel),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_status.full),
        .o_push     (push),
        .o_item     (f_item)
    );

    tts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_status(q_status)
    );

    tts_back #(
        .MAX_STORED_WIDTH(MAX_STORED_WIDTH),
        .MAX_DOWNSHIFT   (MAX_DOWNSHIFT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_status.empty),
        .i_item        (q_item),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_word_address(o_word_address),
        .o_write_data  (o_write_data)
    );

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> !push)
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.empty |-> !pop)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= tts_pkg::QUEUE_CNT_W'(tts_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// File: rtl/tts_front.sv
// ----------------------------------------------------------------------------
// tts_front
// Holds the configuration, tracks the raster position and classifies each
// texel: kept or dropped, first and last sample of its block, word address.
// ----------------------------------------------------------------------------
module tts_front #(
    parameter int MAX_STORED_WIDTH = 1024,
    parameter int MAX_DOWNSHIFT    = 3
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [31:0]                    i_src_texel,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_q_full,
    output logic                           o_push,
    output tts_pkg::t_item                 o_item
);

    localparam int          SH_CAP = (MAX_DOWNSHIFT > 3) ? 3 : MAX_DOWNSHIFT;
    localparam logic [1:0]  SH_MAX = 2'(SH_CAP);

    logic [7:0]  r_tiles_across;
    logic [10:0] r_stored_width;
    logic [10:0] r_stored_height;
    logic [1:0]  r_downshift;
    logic [12:0] r_rect_x;
    logic [12:0] r_rect_y;
    logic [13:0] r_rect_width;
    logic [13:0] r_rect_height;
    logic [12:0] r_col;
    logic [12:0] r_row;
    logic [12:0] n_col;
    logic [12:0] n_row;

    logic [13:0] w;
    logic [13:0] h;
    logic [1:0]  sh;
    logic [2:0]  mask;
    logic [13:0] sx;
    logic [13:0] sy;
    logic [13:0] dx;
    logic [13:0] dy;
    logic [13:0] col_inc;
    logic [13:0] row_inc;
    logic        keep;
    logic [15:0] tile_prod;
    logic [16:0] tile;
    logic        accept;
    logic        cfg_accept;

    assign o_ready     = !i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign cfg_accept  = i_cfg_valid;

    always_comb begin
        w       = tts_pkg::rect_dim(r_rect_width);
        h       = tts_pkg::rect_dim(r_rect_height);
        sh      = (r_downshift > SH_MAX) ? SH_MAX : r_downshift;
        mask    = 3'((4'd1 << sh) - 4'd1);
        sx      = {1'b0, r_rect_x} + {1'b0, r_col};
        sy      = {1'b0, r_rect_y} + {1'b0, r_row};
        dx      = sx >> sh;
        dy      = sy >> sh;
        col_inc = {1'b0, r_col} + 14'd1;
        row_inc = {1'b0, r_row} + 14'd1;
        keep    = (dx < {3'b0, r_stored_width}) && (dx < 14'(MAX_STORED_WIDTH)) &&
                  (dy < {3'b0, r_stored_height});

        tile_prod = dy[10:3] * r_tiles_across;
        tile      = {1'b0, tile_prod} + {9'b0, dx[10:3]};

        o_item.texel = i_src_texel;
        o_item.dx    = dx[10:0];
        o_item.addr  = {tile[13:0], tts_pkg::morton3(dx[2:0], dy[2:0])};
        o_item.first = ((r_row == 13'd0) || ((sy[2:0] & mask) == 3'd0)) &&
                       ((r_col == 13'd0) || ((sx[2:0] & mask) == 3'd0));
        o_item.last  = ((row_inc >= h) || ((sy[2:0] & mask) == mask)) &&
                       ((col_inc >= w) || ((sx[2:0] & mask) == mask));
        o_push       = accept && keep;

        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col_inc >= w) begin
                n_col = 13'd0;
                n_row = (row_inc >= h) ? 13'd0 : row_inc[12:0];
            end else begin
                n_col = col_inc[12:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiles_across  <= 8'd1;
            r_stored_width  <= 11'd8;
            r_stored_height <= 11'd8;
            r_downshift     <= 2'd0;
            r_rect_x        <= 13'd0;
            r_rect_y        <= 13'd0;
            r_rect_width    <= 14'd1;
            r_rect_height   <= 14'd1;
            r_col           <= 13'd0;
            r_row           <= 13'd0;
        end else if (cfg_accept) begin
            // Any register write restarts the upload at the top left.
            r_col <= 13'd0;
            r_row <= 13'd0;
            case (i_cfg_index)
                tts_pkg::CFG_TILES_ACROSS:  r_tiles_across  <= i_cfg_data[7:0];
                tts_pkg::CFG_STORED_WIDTH:  r_stored_width  <= i_cfg_data[10:0];
                tts_pkg::CFG_STORED_HEIGHT: r_stored_height <= i_cfg_data[10:0];
                tts_pkg::CFG_DOWNSHIFT:     r_downshift     <= i_cfg_data[1:0];
                tts_pkg::CFG_RECT_X:        r_rect_x        <= i_cfg_data[12:0];
                tts_pkg::CFG_RECT_Y:        r_rect_y        <= i_cfg_data[12:0];
                tts_pkg::CFG_RECT_WIDTH:    r_rect_width    <= i_cfg_data[13:0];
                tts_pkg::CFG_RECT_HEIGHT:   r_rect_height   <= i_cfg_data[13:0];
                default: begin
                end
            endcase
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// File: rtl/tts_queue.sv
// ----------------------------------------------------------------------------
// tts_queue
// Short FIFO of classified samples between the front and the back.
// ----------------------------------------------------------------------------
module tts_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tts_pkg::t_item     i_item,
    input  logic               i_pop,
    output tts_pkg::t_item     o_item,
    output tts_pkg::t_q_status o_status
);

    tts_pkg::t_item                      r_mem [tts_pkg::QUEUE_DEPTH];
    logic [tts_pkg::QUEUE_PTR_W-1:0]     r_wr;
    logic [tts_pkg::QUEUE_PTR_W-1:0]     r_rd;
    logic [tts_pkg::QUEUE_CNT_W-1:0]     r_cnt;

    assign o_item         = r_mem[r_rd];
    assign o_status.count = r_cnt;
    assign o_status.full  = (r_cnt == tts_pkg::QUEUE_CNT_W'(tts_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/tts_back.sv
// ----------------------------------------------------------------------------
// tts_back
// Accumulates channel sums per stored column, divides them by the sample
// count with restoring dividers, one per channel and shared by all columns,
// and holds the finished word.
module tts_back #(
    parameter int MAX_STORED_WIDTH = 1024,
    parameter int MAX_DOWNSHIFT    = 3
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  tts_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [19:0]    o_word_address,
    output logic [31:0]    o_write_data
);

    localparam int IDX_W   = (MAX_STORED_WIDTH > 1) ? $clog2(MAX_STORED_WIDTH) : 1;
    localparam int SUM_W   = 8 + 2 * MAX_DOWNSHIFT;
    localparam int CNT_W   = 2 * MAX_DOWNSHIFT + 1;
    localparam int ENTRY_W = 4 * SUM_W + CNT_W;
    localparam int STEP_W  = $clog2(SUM_W + 1);

    tts_pkg::t_back_state r_state;
    tts_pkg::t_back_state n_state;

    logic [ENTRY_W-1:0] r_mem [MAX_STORED_WIDTH];
    logic [ENTRY_W-1:0] r_rdata;
    logic [IDX_W-1:0]   r_idx;
    logic [31:0]        r_texel;
    logic               r_first;
    logic               r_last;
    logic [19:0]        r_addr;

    logic [SUM_W-1:0]   r_quo [4];
    logic [CNT_W-1:0]   r_rem [4];
    logic [CNT_W-1:0]   r_div;
    logic [STEP_W-1:0]  r_step;

    logic [SUM_W-1:0]   new_sum [4];
    logic [CNT_W-1:0]   new_cnt;
    logic [ENTRY_W-1:0] new_entry;
    logic [ENTRY_W-1:0] base;
    logic [SUM_W-1:0]   step_quo [4];
    logic [CNT_W-1:0]   step_rem [4];
    logic [CNT_W:0]     trial [4];
    logic               ge [4];
    logic               load;
    logic               div_en;

    always_comb begin
        base = r_first ? '0 : r_rdata;
        for (int c = 0; c < 4; c++) begin
            new_sum[c] = base[c*SUM_W +: SUM_W] + SUM_W'(r_texel[c*8 +: 8]);
        end
        new_cnt   = base[4*SUM_W +: CNT_W] + 1'b1;
        new_entry = {new_cnt, new_sum[3], new_sum[2], new_sum[1], new_sum[0]};

        // One quotient bit per channel each cycle.
        for (int c = 0; c < 4; c++) begin
            trial[c]    = {r_rem[c], r_quo[c][SUM_W-1]};
            ge[c]       = trial[c] >= {1'b0, r_div};
            step_rem[c] = ge[c] ? CNT_W'(trial[c] - {1'b0, r_div}) : CNT_W'(trial[c]);
            step_quo[c] = {r_quo[c][SUM_W-2:0], ge[c]};
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        load    = 1'b0;
        div_en  = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            tts_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_state = tts_pkg::BK_ACC;
                end
            end
            tts_pkg::BK_ACC: begin
                load    = 1'b1;
                n_state = r_last ? tts_pkg::BK_DIV : tts_pkg::BK_IDLE;
            end
            tts_pkg::BK_DIV: begin
                div_en = 1'b1;
                if (r_step == STEP_W'(1)) begin
                    n_state = tts_pkg::BK_OUT;
                end
            end
            tts_pkg::BK_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = tts_pkg::BK_IDLE;
                end
            end
            default: n_state = tts_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tts_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rdata <= r_mem[IDX_W'(i_item.dx)];
            r_idx   <= IDX_W'(i_item.dx);
            r_texel <= i_item.texel;
            r_first <= i_item.first;
            r_last  <= i_item.last;
            r_addr  <= i_item.addr;
        end
        if (load) begin
            r_mem[r_idx] <= new_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int c = 0; c < 4; c++) begin
                r_quo[c] <= new_sum[c];
                r_rem[c] <= '0;
            end
            r_div  <= new_cnt;
            r_step <= STEP_W'(SUM_W);
        end else if (div_en) begin
            for (int c = 0; c < 4; c++) begin
                r_quo[c] <= step_quo[c];
                r_rem[c] <= step_rem[c];
            end
            r_step <= r_step - 1'b1;
        end
    end

    assign o_word_address = r_addr;
    assign o_write_data   = {r_quo[0][7:0], r_quo[1][7:0], r_quo[2][7:0], r_quo[3][7:0]};

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for tiled_texture_swizzle_downscale
// Streams random and directed texel uploads through the block under many
// register settings and compares every tiled write against a box-average
// predictor kept in a scoreboard class.
// ----------------------------------------------------------------------------
module testbench;

    class tex_scoreboard;
        typedef struct {
            bit [19:0] addr;
            bit [31:0] data;
        } t_tile_write;

        bit [7:0]    tiles_across;
        bit [10:0]   stored_w;
        bit [10:0]   stored_h;
        bit [1:0]    shift;
        bit [12:0]   rect_x;
        bit [12:0]   rect_y;
        bit [13:0]   rect_w;
        bit [13:0]   rect_h;
        bit [12:0]   col;
        bit [12:0]   row;
        int unsigned sum_r[1024];
        int unsigned sum_g[1024];
        int unsigned sum_b[1024];
        int unsigned sum_a[1024];
        int unsigned sum_n[1024];
        t_tile_write pending_writes[$];
        int          errors;

        function new();
            tiles_across = 1;
            stored_w = 8;
            stored_h = 8;
            shift = 0;
            rect_x = 0;
            rect_y = 0;
            rect_w = 1;
            rect_h = 1;
            col = 0;
            row = 0;
            errors = 0;
        endfunction

        function void write_reg(bit [tts_pkg::CFG_IDX_W-1:0] idx,
                                bit [tts_pkg::CFG_DATA_W-1:0] v);
            case (idx)
                tts_pkg::CFG_TILES_ACROSS:  tiles_across = v[7:0];
                tts_pkg::CFG_STORED_WIDTH:  stored_w = v[10:0];
                tts_pkg::CFG_STORED_HEIGHT: stored_h = v[10:0];
                tts_pkg::CFG_DOWNSHIFT:     shift = v[1:0];
                tts_pkg::CFG_RECT_X:        rect_x = v[12:0];
                tts_pkg::CFG_RECT_Y:        rect_y = v[12:0];
                tts_pkg::CFG_RECT_WIDTH:    rect_w = v[13:0];
                tts_pkg::CFG_RECT_HEIGHT:   rect_h = v[13:0];
                default: begin
                end
            endcase
            col = 0;
            row = 0;
        endfunction

        function int unsigned clamp_dim(bit [13:0] v);
            if (v == 0) return 1;
            if (v > 8192) return 8192;
            return v;
        endfunction

        function void note_texel(bit [31:0] t);
            int unsigned w, h, msk, sx, sy, dx, dy, n, tile, z, c, r;
            bit          first, last;
            t_tile_write wr;
            w = clamp_dim(rect_w);
            h = clamp_dim(rect_h);
            msk = (1 << shift) - 1;
            c = col;
            r = row;
            sx = rect_x + c;
            sy = rect_y + r;
            dx = sx >> shift;
            dy = sy >> shift;
            if (dx < stored_w && dx < 1024 && dy < stored_h) begin
                first = (r == 0 || (sy & msk) == 0) && (c == 0 || (sx & msk) == 0);
                last = (r + 1 >= h || (sy & msk) == msk) && (c + 1 >= w || (sx & msk) == msk);
                if (first) begin
                    sum_r[dx] = 0;
                    sum_g[dx] = 0;
                    sum_b[dx] = 0;
                    sum_a[dx] = 0;
                    sum_n[dx] = 0;
                end
                sum_r[dx] += t[7:0];
                sum_g[dx] += t[15:8];
                sum_b[dx] += t[23:16];
                sum_a[dx] += t[31:24];
                sum_n[dx] += 1;
                if (last) begin
                    n = sum_n[dx];
                    z = 0;
                    for (int i = 0; i < 3; i++) begin
                        z |= ((dx >> i) & 1) << (2 * i);
                        z |= ((dy >> i) & 1) << (2 * i + 1);
                    end
                    tile = (dy / 8) * tiles_across + dx / 8;
                    wr.addr = 20'((tile << 6) + z);
                    wr.data = {8'(sum_r[dx] / n), 8'(sum_g[dx] / n),
                               8'(sum_b[dx] / n), 8'(sum_a[dx] / n)};
                    pending_writes.push_back(wr);
                end
            end
            c++;
            if (c >= w) begin
                c = 0;
                r++;
                if (r >= h) r = 0;
            end
            col = c;
            row = r;
        endfunction

        function void check_result(bit [19:0] addr, bit [31:0] data);
            t_tile_write wr;
            if (pending_writes.size() == 0) begin
                $display("%0t: unexpected write addr %h data %h", $time, addr, data);
                errors++;
                return;
            end
            wr = pending_writes.pop_front();
            if (wr.addr !== addr) begin
                $display("%0t: address expected %h actual %h", $time, wr.addr, addr);
                errors++;
            end
            if (wr.data !== data) begin
                $display("%0t: data expected %h actual %h", $time, wr.data, data);
                errors++;
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    logic [31:0]                    i_src_texel;
    logic                           o_valid;
    logic                           i_ready;
    logic [19:0]                    o_word_address;
    logic [31:0]                    o_write_data;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [tts_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [tts_pkg::CFG_DATA_W-1:0] i_cfg_data;

    tex_scoreboard sb = new();
    bit            calm;
    bit            hold_req;
    int            hold_left;
    int            texels_sent;

    tiled_texture_swizzle_downscale uut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = 300;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 9);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_texel(i_src_texel);
            if (o_valid && i_ready) sb.check_result(o_word_address, o_write_data);
        end
    end

    task automatic send_texel(input bit [31:0] t);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_src_texel <= t;
        do @(posedge i_clk); while (!o_ready);
        texels_sent++;
    endtask

    task automatic write_reg(input bit [tts_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned field, input int width);
        bit [tts_pkg::CFG_DATA_W-1:0] v;
        // Bits above the register's width carry noise; the block must ignore them.
        v = tts_pkg::CFG_DATA_W'(($urandom() << width) | field);
        @(negedge i_clk);
        i_valid <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending_writes.size() != 0) @(posedge i_clk);
        // Samples that end no block can still sit in the queue with no write pending.
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_all(input int unsigned ta, sw, sh, ds, rx, ry, rw, rh);
        write_reg(tts_pkg::CFG_TILES_ACROSS, ta, 8);
        write_reg(tts_pkg::CFG_STORED_WIDTH, sw, 11);
        write_reg(tts_pkg::CFG_STORED_HEIGHT, sh, 11);
        write_reg(tts_pkg::CFG_DOWNSHIFT, ds, 2);
        write_reg(tts_pkg::CFG_RECT_X, rx, 13);
        write_reg(tts_pkg::CFG_RECT_Y, ry, 13);
        write_reg(tts_pkg::CFG_RECT_WIDTH, rw, 14);
        write_reg(tts_pkg::CFG_RECT_HEIGHT, rh, 14);
    endtask

    function automatic bit [31:0] rand_texel();
        case ($urandom_range(7))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic int unsigned rand_dim();
        case ($urandom_range(15))
            0:       return 0;
            1:       return 8192;
            2:       return 16383;
            default: return $urandom_range(1, 24);
        endcase
    endfunction

    function automatic int unsigned rand_pos();
        case ($urandom_range(9))
            0:       return 8191;
            1:       return $urandom_range(8191);
            default: return $urandom_range(40);
        endcase
    endfunction

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int unsigned ta, sw, sh, ds, rx, ry, rw, rh, count;
        int          phase;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_src_texel = '0;
        i_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        calm = 0;
        hold_req = 0;
        hold_left = 0;
        texels_sent = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: a 1x1 rectangle, so every texel is written at once.
        send_texel(32'h0);
        send_texel(32'hFFFF_FFFF);
        send_texel(32'h1234_5678);
        send_texel($urandom());
        drain();

        // Far corner of the largest store: zero width acts as one and an
        // oversized height is clamped, with an 8x8 box down one column.
        set_all(128, 1024, 1024, 3, 8184, 8184, 0, 16383);
        repeat (8) send_texel(rand_texel());
        drain();

        // Columns beyond the stored width are dropped; rows beyond the stored height too.
        set_all(255, 1, 2047, 0, 0, 8190, 3, 2);
        repeat (6) send_texel(rand_texel());
        drain();

        phase = 0;
        while (texels_sent < 1600) begin
            calm = (phase == 3);
            ta = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(1, 4);
            sw = ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(1, 40);
            sh = ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(1, 40);
            ds = $urandom_range(3);
            rx = rand_pos();
            ry = rand_pos();
            rw = rand_dim();
            rh = rand_dim();
            if (phase == 4) begin
                // Many writes back to back while the receiver holds off.
                ds = 0;
                sw = 1024;
                sh = 1024;
                rx = 0;
                ry = 0;
                rw = 16;
                rh = 16;
            end
            set_all(ta, sw, sh, ds, rx, ry, rw, rh);
            count = sb.clamp_dim(rw) * sb.clamp_dim(rh) * $urandom_range(1, 2)
                    + $urandom_range(5);
            if (count > 200) count = $urandom_range(40, 200);
            if (phase == 4) hold_req = 1;
            repeat (count) send_texel(rand_texel());
            drain();
            phase++;
        end

        if (sb.errors == 0 && sb.pending_writes.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/tts_pkg.sv
rtl/tts_front.sv
rtl/tts_queue.sv
rtl/tts_back.sv
rtl/tiled_texture_swizzle_downscale.sv
sim/testbench.sv
